### design/whl2_pkg.sv
// Shared types, constants and the mix function for the word hash lookup2 unit.
`default_nettype none

package whl2_pkg;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    localparam int MIX_SHIFT_A [3] = '{13, 12, 3};
    localparam int MIX_SHIFT_B [3] = '{8, 16, 10};
    localparam int MIX_SHIFT_C [3] = '{13, 5, 15};

    typedef enum logic
    {
        REG_SEED         = 1'b0,
        REG_BUCKET_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        SLOT_A = 2'd0,
        SLOT_B = 2'd1,
        SLOT_C = 2'd2
    } slot_t;

    typedef struct packed
    {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    typedef struct packed
    {
        logic        valid;
        logic        mixed;
        logic [31:0] pend_a;
        logic [31:0] pend_b;
        logic [31:0] add_c;
    } final_tok_t;

    typedef struct packed
    {
        logic [31:0] hash_value;
        logic [31:0] bucket_index;
    } hash_result_t;

    // one third of the mix: three rows on a, b and c
    function automatic abc_t mix_third(input abc_t x, input int part);
        abc_t y;
        y = x;
        y.a = (y.a - y.b - y.c) ^ (y.c >> MIX_SHIFT_A[part]);
        y.b = (y.b - y.c - y.a) ^ (y.a << MIX_SHIFT_B[part]);
        y.c = (y.c - y.a - y.b) ^ (y.b >> MIX_SHIFT_C[part]);
        return y;
    endfunction

endpackage

`default_nettype wire

### design/whl2_channels.sv
// Valid/ready channel interfaces for message words and hash results.
`default_nettype none

interface whl2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink (input valid, input word, input last_word, output ready);
endinterface

interface whl2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic [31:0] bucket_index;

    modport source (output valid, output hash_value, output bucket_index, input ready);
    modport sink (input valid, input hash_value, input bucket_index, output ready);
endinterface

`default_nettype wire

### design/word_hash_lookup2_unit.sv
// Streaming lookup2 word hash with bucket index, one word per cycle unless stalled.
//
// words:  one 32-bit word per transfer, last_word set on the final word of a message.
//         A message holds at least one word; the next message may follow at once.
// hashes: one transfer per message: hash_value and bucket_index, the upper half
//         of hash_value * bucket_count.
// cfg:    cfg_write with cfg_index / cfg_data writes seed or bucket_count; write
//         only while no message is in flight.
// Throughput: one word per cycle while the output queue has room. The intermediate
// mix after every third word runs in a three-stage loop that closes back on the a/b/c
// accumulators before the next mix. The final mix has its own three-stage pipeline.
// Last word to hashes: input, d_reg[0..2], f1..f3 and tail registers, then the queue.
// Stall: a two-entry output queue holds results; words.ready falls only when the
// queue is full, and the whole pipeline then holds.
// Reset: seed 0, bucket_count 12, pipeline empty, a new message starts.
`default_nettype none

module word_hash_lookup2_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  whl2_pkg::reg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    whl2_in_if.sink              words,
    whl2_out_if.source           hashes
);
    import whl2_pkg::*;

    logic [31:0]  seed_reg;
    logic [31:0]  bucket_count_reg;

    logic         adv;

    logic         in_valid_reg;
    logic [31:0]  in_word_reg;
    logic         in_last_reg;

    slot_t        slot_reg, slot_next;
    logic [31:0]  count_reg, count_next, count_inc;
    logic         mixed_reg, mixed_next;
    logic [31:0]  pend_a_reg, pend_a_next;
    logic [31:0]  pend_b_reg, pend_b_next;
    logic         mix_launch;
    abc_t         base_abc, mix_in;
    final_tok_t   tok;

    abc_t         abc_reg;
    logic         m1_valid_reg, m2_valid_reg;
    abc_t         m1_reg, m2_reg;

    final_tok_t   d_reg [3];
    abc_t         fin_base, fin_in;
    logic         f1_valid_reg, f2_valid_reg, f3_valid_reg;
    abc_t         f1_reg, f2_reg, f3_reg;

    logic [63:0]  product;
    logic         tail_valid_reg;
    hash_result_t tail_reg;

    hash_result_t fifo_reg [2];
    logic [1:0]   fifo_count_reg;
    logic         push, pop;

    assign adv         = (fifo_count_reg != 2'd2);
    assign words.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg         <= 32'd0;
            bucket_count_reg <= 32'd12;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SEED:         seed_reg         <= cfg_data;
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && words.valid)
        begin
            in_word_reg <= words.word;
            in_last_reg <= words.last_word;
        end
    end

    always_comb
    begin
        base_abc    = mixed_reg ? abc_reg : abc_t'{GOLDEN, GOLDEN, seed_reg};
        mix_in      = '{base_abc.a + pend_a_reg, base_abc.b + pend_b_reg,
                        base_abc.c + in_word_reg};
        count_inc   = count_reg + 32'd1;
        slot_next   = slot_reg;
        count_next  = count_reg;
        mixed_next  = mixed_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        mix_launch  = 1'b0;
        tok         = '0;
        if (in_valid_reg)
        begin
            count_next = count_inc;
            case (slot_reg)
                SLOT_B:
                begin
                    pend_b_next = in_word_reg;
                    slot_next   = SLOT_C;
                end
                SLOT_C:
                begin
                    mix_launch  = 1'b1;
                    pend_a_next = 32'd0;
                    pend_b_next = 32'd0;
                    mixed_next  = 1'b1;
                    slot_next   = SLOT_A;
                end
                default:
                begin
                    pend_a_next = in_word_reg;
                    slot_next   = SLOT_B;
                end
            endcase
            if (in_last_reg)
            begin
                tok.valid   = 1'b1;
                tok.mixed   = mixed_next;
                tok.pend_a  = pend_a_next;
                tok.pend_b  = pend_b_next;
                tok.add_c   = {count_inc[29:0], 2'b00};
                slot_next   = SLOT_A;
                count_next  = 32'd0;
                mixed_next  = 1'b0;
                pend_a_next = 32'd0;
                pend_b_next = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= SLOT_A;
            count_reg    <= 32'd0;
            mixed_reg    <= 1'b0;
            pend_a_reg   <= 32'd0;
            pend_b_reg   <= 32'd0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            d_reg[0]     <= '0;
            d_reg[1]     <= '0;
            d_reg[2]     <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            slot_reg     <= slot_next;
            count_reg    <= count_next;
            mixed_reg    <= mixed_next;
            pend_a_reg   <= pend_a_next;
            pend_b_reg   <= pend_b_next;
            m1_valid_reg <= mix_launch;
            m2_valid_reg <= m1_valid_reg;
            d_reg[0]     <= tok;
            d_reg[1]     <= d_reg[0];
            d_reg[2]     <= d_reg[1];
            f1_valid_reg <= d_reg[2].valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            tail_valid_reg <= f3_valid_reg;
        end
    end

    always_comb
    begin
        fin_base = d_reg[2].mixed ? abc_reg : abc_t'{GOLDEN, GOLDEN, seed_reg};
        fin_in   = '{fin_base.a + d_reg[2].pend_a, fin_base.b + d_reg[2].pend_b,
                     fin_base.c + d_reg[2].add_c};
    end

    assign product = {32'd0, f3_reg.c} * {32'd0, bucket_count_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= mix_third(mix_in, 0);
            m2_reg <= mix_third(m1_reg, 1);
            if (m2_valid_reg)
            begin
                abc_reg <= mix_third(m2_reg, 2);
            end
            f1_reg <= mix_third(fin_in, 0);
            f2_reg <= mix_third(f1_reg, 1);
            f3_reg <= mix_third(f2_reg, 2);
            tail_reg.hash_value   <= f3_reg.c;
            tail_reg.bucket_index <= product[63:32];
        end
    end

    assign push = tail_valid_reg && adv;
    assign pop  = hashes.valid && hashes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            fifo_count_reg <= fifo_count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fifo_count_reg <= fifo_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (fifo_count_reg == 2'd0)
            begin
                fifo_reg[0] <= tail_reg;
            end
            else
            begin
                fifo_reg[1] <= tail_reg;
            end
        end
        else if (pop && !push)
        begin
            fifo_reg[0] <= fifo_reg[1];
        end
        else if (pop && push)
        begin
            fifo_reg[0] <= tail_reg;
        end
    end

    assign hashes.valid        = (fifo_count_reg != 2'd0);
    assign hashes.hash_value   = fifo_reg[0].hash_value;
    assign hashes.bucket_index = fifo_reg[0].bucket_index;

endmodule

`default_nettype wire
